// ===== rtl/core/itp_pkg.sv =====
// Package for the integer text parser: widths, character codes, parse phases,
// the per-text state record and the character classification functions.
// No dependencies.
`default_nettype none

package itp_pkg;

    localparam int MAX_CHARS = 256;
    localparam int POS_W     = $clog2(MAX_CHARS + 1);
    localparam int CHAR_W    = 8;
    localparam int RADIX_W   = 6;
    localparam int VALUE_W   = 32;
    localparam int OFFSET_W  = 9;
    localparam int DIGIT_W   = 7;
    localparam int WIDE_W    = VALUE_W + 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [PADDR_W-1:0] REG_RADIX_MODE = 3'd0;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_DETECT  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ILLEGAL = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_OCT     = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC     = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX     = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_X   = 8'd88;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LO_X   = 8'd120;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'd122;
    localparam logic [CHAR_W-1:0] UPPER_BIAS = 8'd55;
    localparam logic [CHAR_W-1:0] LOWER_BIAS = 8'd87;
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(-64'sd2147483648);

    typedef enum logic [2:0] {
        PH_WS     = 3'd0,
        PH_PREFIX = 3'd1,
        PH_AFTER0 = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase                     phase;
        logic                       neg;
        logic signed [VALUE_W-1:0]  acc;
        logic [POS_W-1:0]           pos;
        logic [RADIX_W-1:0]         radix;
        logic [CHAR_W-1:0]          prev;
        logic [POS_W-1:0]           endp;
    } t_parse_state;

    localparam t_parse_state ST_CLEAR = '{
        phase: PH_WS, neg: 1'b0, acc: '0, pos: '0, radix: '0, prev: '0, endp: '0
    };

    function automatic logic f_is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic f_is_alnum(input logic [CHAR_W-1:0] c);
        return (c inside {[CH_ZERO:CH_NINE]}) || (c inside {[CH_UP_A:CH_UP_Z]})
            || (c inside {[CH_LO_A:CH_LO_Z]});
    endfunction

    function automatic logic [DIGIT_W-1:0] f_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = 8'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = c - CH_ZERO;
        end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            d = c - UPPER_BIAS;
        end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
            d = c - LOWER_BIAS;
        end else begin
            return DIGIT_NONE;
        end
        return d[DIGIT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itp_if.sv =====
// Stream interfaces of the integer text parser: character beats in,
// result beats out. Depends on itp_pkg.
`default_nettype none

interface itp_char_if import itp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface itp_result_if import itp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] parsed_value;
    logic [OFFSET_W-1:0]       end_offset;

    modport source (output valid, output parsed_value, output end_offset, input ready);
    modport sink   (input valid, input parsed_value, input end_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/itp_cfg.sv =====
// APB register block of the integer text parser: holds radix_mode.
// Depends on itp_pkg.
`default_nettype none

module itp_cfg import itp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [RADIX_W-1:0] o_radix_mode
);

    logic [RADIX_W-1:0] r_radix_mode;
    logic               wr_radix;

    assign pready   = 1'b1;
    assign wr_radix = psel && penable && pwrite && (paddr == REG_RADIX_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_mode <= RADIX_RESET;
        end else if (wr_radix) begin
            r_radix_mode <= pwdata[RADIX_W-1:0];
        end
    end

    assign prdata       = (paddr == REG_RADIX_MODE) ? PDATA_W'(r_radix_mode) : '0;
    assign o_radix_mode = r_radix_mode;

endmodule

`default_nettype wire

// ===== rtl/core/itp_step.sv =====
// Per-character parse step: next text state, value and end offset for one
// character beat. Depends on itp_pkg.
`default_nettype none

module itp_step import itp_pkg::*; (
    input  wire t_parse_state         i_state,
    input  wire logic [CHAR_W-1:0]    i_char,
    input  wire logic                 i_last,
    input  wire logic [RADIX_W-1:0]   i_radix_mode,
    output t_parse_state              o_next,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [OFFSET_W-1:0]       o_offset
);

    function automatic t_parse_state f_take(input t_parse_state s,
                                            input logic [CHAR_W-1:0] c);
        t_parse_state t;
        t      = s;
        t.endp = s.pos + 1'b1;
        t.prev = c;
        return t;
    endfunction

    function automatic t_parse_state f_finish(input t_parse_state s);
        t_parse_state t;
        t = s;
        if (s.phase != PH_DONE) begin
            if (s.radix == RADIX_HEX && (s.prev == CH_LO_X || s.prev == CH_UP_X)) begin
                t.endp = s.endp - 1'b1;
                t.prev = CH_ZERO;
            end
            t.phase = PH_DONE;
        end
        return t;
    endfunction

    always_comb begin : step
        t_parse_state              s;
        t_parse_state              fin;
        logic                      handled;
        logic [DIGIT_W-1:0]        dv;
        logic signed [WIDE_W-1:0]  v;

        s       = i_state;
        handled = 1'b0;
        dv      = f_digit(i_char);
        v       = '0;

        if (s.pos == '0) begin
            s.radix = i_radix_mode;
            if (i_radix_mode == RADIX_ILLEGAL || i_radix_mode > RADIX_MAX) begin
                s.phase = PH_DONE;
                s.radix = '0;
            end
        end

        if (s.phase != PH_DONE) begin
            if (i_char == CH_NUL || s.pos >= POS_W'(MAX_CHARS)) begin
                s = f_finish(s);
            end else begin
                if (s.phase == PH_WS) begin
                    if (f_is_space(i_char)) begin
                        s       = f_take(s, i_char);
                        handled = 1'b1;
                    end else begin
                        s.phase = PH_PREFIX;
                        if (i_char == CH_MINUS || i_char == CH_PLUS) begin
                            s.neg   = (i_char == CH_MINUS);
                            s       = f_take(s, i_char);
                            handled = 1'b1;
                        end
                    end
                end
                if (!handled && s.phase == PH_PREFIX) begin
                    if (i_char == CH_ZERO && (s.radix == RADIX_HEX || s.radix == RADIX_DETECT)) begin
                        s       = f_take(s, i_char);
                        s.phase = PH_AFTER0;
                        handled = 1'b1;
                    end else begin
                        if (s.radix == RADIX_DETECT) begin
                            s.radix = RADIX_DEC;
                        end
                        s.phase = PH_DIGITS;
                    end
                end
                if (!handled && s.phase == PH_AFTER0) begin
                    if (i_char == CH_LO_X || i_char == CH_UP_X) begin
                        s.radix = RADIX_HEX;
                        s       = f_take(s, i_char);
                        s.phase = PH_DIGITS;
                        handled = 1'b1;
                    end else begin
                        if (s.radix == RADIX_DETECT) begin
                            s.radix = RADIX_OCT;
                        end
                        s.phase = PH_DIGITS;
                    end
                end
                if (!handled && s.phase == PH_DIGITS) begin
                    if (dv < {1'b0, s.radix}) begin
                        v = WIDE_W'($signed(s.acc)) * WIDE_W'($signed({1'b0, s.radix}));
                        if (s.neg) begin
                            v = v - $signed(WIDE_W'(dv));
                        end else begin
                            v = v + $signed(WIDE_W'(dv));
                        end
                        if (v > WIDE_MAX) begin
                            v = WIDE_MAX;
                        end else if (v < WIDE_MIN) begin
                            v = WIDE_MIN;
                        end
                        s.acc = v[VALUE_W-1:0];
                        s     = f_take(s, i_char);
                    end else begin
                        s = f_finish(s);
                    end
                end
            end
        end

        if (s.pos < POS_W'(MAX_CHARS)) begin
            s.pos = s.pos + 1'b1;
        end

        fin      = f_finish(s);
        o_value  = fin.acc;
        o_offset = f_is_alnum(fin.prev) ? OFFSET_W'(fin.endp) : '0;

        if (i_last) begin
            o_next = ST_CLEAR;
        end else begin
            o_next = s;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/integer_text_parser_top.sv =====
// Integer text parser, top level: character input register, text state with
// one parse step per beat, result register. Depends on itp_pkg, itp_if,
// itp_cfg and itp_step.
// Throughput: one character beat per cycle unless the input stalls. The result
// register loads from the input register's last beat, waiting only on an earlier result.
// The cycle is set by the multiply-accumulate in itp_step.
// Input stalls only while a last beat waits on an unaccepted result.
// Reset (synchronous, active low) clears the text state, empties both registers
// and sets radix_mode to 10.
`default_nettype none

module integer_text_parser_top import itp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    itp_char_if.sink                i_char,
    itp_result_if.source            o_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [RADIX_W-1:0]        radix_mode;
    logic                      r_s1_valid;
    logic [CHAR_W-1:0]         r_s1_char;
    logic                      r_s1_last;
    t_parse_state              r_st;
    t_parse_state              n_st;
    logic signed [VALUE_W-1:0] n_value;
    logic [OFFSET_W-1:0]       n_offset;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [OFFSET_W-1:0]       r_out_offset;
    logic                      s1_adv;
    logic                      in_ready;
    logic                      in_fire;
    logic                      load_out;

    itp_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_radix_mode (radix_mode)
    );

    itp_step u_step (
        .i_state      (r_st),
        .i_char       (r_s1_char),
        .i_last       (r_s1_last),
        .i_radix_mode (radix_mode),
        .o_next       (n_st),
        .o_value      (n_value),
        .o_offset     (n_offset)
    );

    assign s1_adv   = r_s1_valid && (!r_s1_last || !r_out_valid || o_result.ready);
    assign in_ready = !r_s1_valid || s1_adv;
    assign in_fire  = i_char.valid && in_ready;
    assign load_out = s1_adv && r_s1_last;

    assign i_char.ready          = in_ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.parsed_value = r_out_value;
    assign o_result.end_offset   = r_out_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= ST_CLEAR;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_char.valid;
            end
            if (s1_adv) begin
                r_st <= n_st;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_char <= i_char.char_code;
            r_s1_last <= i_char.is_last;
        end
        if (load_out) begin
            r_out_value  <= n_value;
            r_out_offset <= n_offset;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_st.pos == '0 && r_st.phase == PH_WS))
        else $error("text state not cleared after last beat");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.pos <= POS_W'(MAX_CHARS))
        else $error("position count beyond limit");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(load_out))
        else $error("result without a last beat");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_s1_valid && r_s1_last && r_out_valid))
        else $error("input stalled without a pending last beat");

endmodule

`default_nettype wire
